// ===== rtl/endian_view_load_store_unit_top_macros.svh =====
// assertion macros for the endian view load and store unit
`ifndef ENDIAN_VIEW_LOAD_STORE_UNIT_TOP_MACROS_SVH
`define ENDIAN_VIEW_LOAD_STORE_UNIT_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define EVL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("endian view unit: same-cycle check failed");

// next-cycle implication, checked outside reset
`define EVL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("endian view unit: next-cycle check failed");

`endif

// ===== rtl/evl_pkg.sv =====
// shared types, codes and helpers of the endian view load and store unit
`default_nettype none

package evl_pkg;

    // configuration register port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LENGTH = 1'd1;
    localparam logic [CFG_W-1:0]     VIEW_LENGTH_RST = 13'd4096;

    // request actions
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // result status
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // element kinds
    localparam logic [2:0] KIND_INT8   = 3'd0;
    localparam logic [2:0] KIND_UINT8  = 3'd1;
    localparam logic [2:0] KIND_INT16  = 3'd2;
    localparam logic [2:0] KIND_UINT16 = 3'd3;
    localparam logic [2:0] KIND_INT32  = 3'd4;
    localparam logic [2:0] KIND_UINT32 = 3'd5;
    localparam logic [2:0] KIND_FLT32  = 3'd6;
    localparam logic [2:0] KIND_FLT64  = 3'd7;

    // data widths
    localparam int VAL_W  = 64;
    localparam int WIN_W  = 128;
    localparam int OFS_W  = 16;
    localparam int SIZE_W = 4;

    // per-request lane control handed to the byte datapath
    typedef struct packed {
        logic [2:0] lo;
        logic [2:0] kind;
        logic       little;
    } t_lane_ctl;

    // element size in bytes
    function automatic logic [SIZE_W-1:0] kind_size(input logic [2:0] kind);
        logic [SIZE_W-1:0] sz;
        case (kind)
            KIND_INT8, KIND_UINT8:               sz = 4'd1;
            KIND_INT16, KIND_UINT16:             sz = 4'd2;
            KIND_INT32, KIND_UINT32, KIND_FLT32: sz = 4'd4;
            default:                             sz = 4'd8;
        endcase
        return sz;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/evl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module evl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/evl_bytes.sv =====
// byte lane datapath: extracts and extends a load, merges a store into a 16-byte window
`default_nettype none

module evl_bytes (
    input  wire evl_pkg::t_lane_ctl           i_ctl,
    input  wire logic [evl_pkg::WIN_W-1:0]    i_window,
    input  wire logic [evl_pkg::VAL_W-1:0]    i_wval,
    output logic      [evl_pkg::VAL_W-1:0]    o_load,
    output logic      [evl_pkg::WIN_W-1:0]    o_window
);

    logic [evl_pkg::SIZE_W-1:0] size;
    logic [evl_pkg::WIN_W-1:0]  shifted;
    logic [evl_pkg::VAL_W-1:0]  raw;
    logic [evl_pkg::VAL_W-1:0]  addr_order;

    assign size    = evl_pkg::kind_size(i_ctl.kind);
    assign shifted = i_window >> {i_ctl.lo, 3'b000};

    // gather element bytes from the shifted window in the requested order
    always_comb begin
        logic [evl_pkg::SIZE_W-1:0] t;
        logic [2:0]                 idx;
        raw = '0;
        for (int i = 0; i < 8; i++) begin
            t   = size - 4'd1 - 4'(i);
            idx = i_ctl.little ? 3'(i) : t[2:0];
            if (4'(i) < size) begin
                raw[8*i +: 8] = shifted[{idx, 3'b000} +: 8];
            end
        end
    end

    // sign or zero extension by kind
    always_comb begin
        case (i_ctl.kind)
            evl_pkg::KIND_INT8:  o_load = {{56{raw[7]}}, raw[7:0]};
            evl_pkg::KIND_INT16: o_load = {{48{raw[15]}}, raw[15:0]};
            evl_pkg::KIND_INT32: o_load = {{32{raw[31]}}, raw[31:0]};
            default:             o_load = raw;
        endcase
    end

    // store bytes laid out in address order
    always_comb begin
        logic [evl_pkg::SIZE_W-1:0] t;
        logic [2:0]                 src;
        for (int p = 0; p < 8; p++) begin
            t   = size - 4'd1 - 4'(p);
            src = i_ctl.little ? 3'(p) : t[2:0];
            addr_order[8*p +: 8] = i_wval[{src, 3'b000} +: 8];
        end
    end

    // merge the store bytes over the window
    always_comb begin
        logic [3:0] d;
        for (int k = 0; k < 16; k++) begin
            d = 4'(k) - {1'b0, i_ctl.lo};
            if ((4'(k) >= {1'b0, i_ctl.lo}) && (d < size)) begin
                o_window[8*k +: 8] = addr_order[{d[2:0], 3'b000} +: 8];
            end else begin
                o_window[8*k +: 8] = i_window[8*k +: 8];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/endian_view_load_store_unit_top.sv =====
// top level of the endian view load and store unit
`default_nettype none

`include "endian_view_load_store_unit_top_macros.svh"

// Load and store unit over a byte store of STORE_BYTES bytes, seen through a window set by
// view_base and view_length (clamped to the store end). Each request reads or writes one
// element of 1, 2, 4 or 8 bytes at any byte offset, big-endian unless lsb_first is set;
// loads return the element sign- or zero-extended to 64 bits, accesses that leave the window
// change nothing and return status 1. The store is held as two 64-bit banks of even and odd
// 8-byte words, so an unaligned element touches one row of each bank at most. The
// acceptance cycle reads both banks, the following cycle merges, writes back and loads the
// result register; no new request is taken before that, nor while a result is held unread.
// After reset a clearing pass zeroes the (STORE_BYTES+15)/16 rows (256 for 4096 bytes) of
// each bank; no request is accepted until it ends; configuration writes are taken throughout.
module endian_view_load_store_unit_top #(
    parameter int STORE_BYTES = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [evl_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [evl_pkg::CFG_W-1:0]     i_cfg_wdata,
    // request stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [79:0]                   i_s_axis_tdata,  // offset, write_value
    input  wire logic [7:0]                    i_s_axis_tuser,  // action, access_kind, lsb_first
    // result stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [63:0]                        o_m_axis_tdata,  // read_value
    output logic                               o_m_axis_tuser   // status
);

    localparam int BANK_DEPTH = (STORE_BYTES + 15) / 16;
    localparam int RAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int AWB        = $clog2(STORE_BYTES + 1);
    localparam int LW         = (AWB > 17) ? AWB + 1 : 18;
    localparam logic [LW-1:0]  STORE_L  = LW'(STORE_BYTES);
    localparam logic [RAW-1:0] LAST_ROW = RAW'(BANK_DEPTH - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    // configuration and clamped window
    logic [evl_pkg::CFG_W-1:0] r_view_base, n_view_base;
    logic [evl_pkg::CFG_W-1:0] r_view_length, n_view_length;
    logic [LW-1:0]             r_base_c, n_base_c;
    logic [LW-1:0]             r_len_c, n_len_c;
    logic [LW-1:0]             base_x, len_x, room;

    // control
    logic [1:0]     r_state, n_state;
    logic [RAW-1:0] r_clr_row;
    logic           r_out_valid;
    logic           accept;

    // request decode
    logic                       in_act, in_le;
    logic [2:0]                 in_kind;
    logic [evl_pkg::OFS_W-1:0]  in_ofs;
    logic [evl_pkg::SIZE_W-1:0] in_size;
    logic [LW-1:0]              end_x, addr, w0, w1;
    logic [2:0]                 in_lo;
    logic                       in_err, in_hi;
    logic [RAW-1:0]             rd_row_even, rd_row_odd;

    // stored request
    evl_pkg::t_lane_ctl         r_ctl;
    logic                       r_act, r_err, r_par, r_hi;
    logic [RAW-1:0]             r_row_even, r_row_odd;
    logic [evl_pkg::VAL_W-1:0]  r_wval;
    logic [evl_pkg::VAL_W-1:0]  r_rd_value;
    logic                       r_status;

    // banks and datapath
    logic                       even_we, odd_we;
    logic [RAW-1:0]             even_waddr, odd_waddr;
    logic [evl_pkg::VAL_W-1:0]  even_wdata, odd_wdata, even_rdata, odd_rdata;
    logic [evl_pkg::WIN_W-1:0]  window, merged;
    logic [evl_pkg::VAL_W-1:0]  load_val;
    logic                       store_ok;

    // configuration next values and window clamp
    always_comb begin
        n_view_base   = r_view_base;
        n_view_length = r_view_length;
        if (!i_rst_n) begin
            n_view_base   = '0;
            n_view_length = evl_pkg::VIEW_LENGTH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == evl_pkg::CFG_VIEW_BASE) begin
                n_view_base = i_cfg_wdata;
            end
            if (i_cfg_addr == evl_pkg::CFG_VIEW_LENGTH) begin
                n_view_length = i_cfg_wdata;
            end
        end
        base_x   = LW'(n_view_base);
        len_x    = LW'(n_view_length);
        n_base_c = (base_x > STORE_L) ? STORE_L : base_x;
        room     = STORE_L - n_base_c;
        n_len_c  = (len_x > room) ? room : len_x;
    end

    // configuration registers, reset through the next values
    always_ff @(posedge i_clk) begin
        r_view_base   <= n_view_base;
        r_view_length <= n_view_length;
        r_base_c      <= n_base_c;
        r_len_c       <= n_len_c;
    end

    // request fields, range check and bank rows
    assign in_act  = i_s_axis_tuser[0];
    assign in_kind = i_s_axis_tuser[3:1];
    assign in_le   = i_s_axis_tuser[4];
    assign in_ofs  = i_s_axis_tdata[15:0];
    assign in_size = evl_pkg::kind_size(in_kind);

    always_comb begin
        end_x       = LW'(in_ofs) + LW'(in_size);
        in_err      = end_x > r_len_c;
        addr        = r_base_c + LW'(in_ofs);
        in_lo       = addr[2:0];
        w0          = addr >> 3;
        w1          = w0 + LW'(1);
        rd_row_odd  = RAW'(w0 >> 1);
        rd_row_even = RAW'(w1 >> 1);
        in_hi       = ({1'b0, in_lo} + in_size) > 4'd8;
    end

    // handshake
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_row == LAST_ROW) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_row <= r_clr_row + RAW'(1);
            end
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctl.lo     <= in_lo;
            r_ctl.kind   <= in_kind;
            r_ctl.little <= in_le;
            r_act        <= in_act;
            r_err        <= in_err;
            r_par        <= w0[0];
            r_hi         <= in_hi;
            r_row_even   <= rd_row_even;
            r_row_odd    <= rd_row_odd;
            r_wval       <= i_s_axis_tdata[79:16];
        end
    end

    // window assembly from the two banks
    assign window = r_par ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};

    evl_bytes u_bytes (
        .i_ctl    (r_ctl),
        .i_window (window),
        .i_wval   (r_wval),
        .o_load   (load_val),
        .o_window (merged)
    );

    // bank write ports: clearing pass or store write-back
    assign store_ok = (r_state == S_EXEC) && (r_act == evl_pkg::ACT_WRITE) && !r_err;

    always_comb begin
        if (r_state == S_CLEAR) begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_waddr = r_clr_row;
            odd_waddr  = r_clr_row;
            even_wdata = '0;
            odd_wdata  = '0;
        end else begin
            even_we    = store_ok && (!r_par || r_hi);
            odd_we     = store_ok && (r_par || r_hi);
            even_waddr = r_row_even;
            odd_waddr  = r_row_odd;
            even_wdata = r_par ? merged[127:64] : merged[63:0];
            odd_wdata  = r_par ? merged[63:0] : merged[127:64];
        end
    end

    evl_ram #(
        .WIDTH (evl_pkg::VAL_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (even_we),
        .i_waddr (even_waddr),
        .i_wdata (even_wdata),
        .i_raddr (rd_row_even),
        .o_rdata (even_rdata)
    );

    evl_ram #(
        .WIDTH (evl_pkg::VAL_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (odd_we),
        .i_waddr (odd_waddr),
        .i_wdata (odd_wdata),
        .i_raddr (rd_row_odd),
        .o_rdata (odd_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_status   <= r_err ? evl_pkg::STATUS_RANGE : evl_pkg::STATUS_DONE;
            r_rd_value <= (r_err || (r_act == evl_pkg::ACT_WRITE)) ? '0 : load_val;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_rd_value;
    assign o_m_axis_tuser  = r_status;

    // checks
    `EVL_ASSERT_NEXT(a_accept_runs_exec, accept, r_state == S_EXEC)
    `EVL_ASSERT_NOW(a_no_request_in_clear, r_state == S_CLEAR, !o_s_axis_tready)
    `EVL_ASSERT_NOW(a_result_slot_free, r_state == S_EXEC, !r_out_valid)
    `EVL_ASSERT_NOW(a_reject_no_write, (r_state == S_EXEC) && r_err, !even_we && !odd_we)
    `EVL_ASSERT_NEXT(a_exec_gives_result, r_state == S_EXEC, o_m_axis_tvalid)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the endian view load and store unit
`timescale 1ns / 100ps

module testbench;

    localparam int MEM_BYTES  = 4096;
    localparam int LONG_HOLD  = 400;
    localparam int PHASE_SIZE = 165;

    // one request as it travels on the request stream
    typedef struct {
        logic [79:0] data;
        logic [7:0]  user;
    } t_access;

    // one result as the unit should return it
    typedef struct {
        logic [63:0] value;
        logic        status;
    } t_outcome;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [evl_pkg::CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [evl_pkg::CFG_W-1:0]     i_cfg_wdata = '0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [79:0]                   i_s_axis_tdata = '0;
    logic [7:0]                    i_s_axis_tuser = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [63:0]                   o_m_axis_tdata;
    logic                          o_m_axis_tuser;

    // stimulus and scoreboard state
    t_access     request_fifo[$];
    t_outcome    outcome_fifo[$];
    logic [7:0]  mem_image[MEM_BYTES];
    logic [12:0] win_base_reg = '0;
    logic [12:0] win_len_reg = evl_pkg::VIEW_LENGTH_RST;
    logic        req_accepted = 1'b0;
    logic        idle_on = 1'b1;
    int          send_gap = 0;
    int          hold_cnt = 0;
    int          long_stall_ask = 0;
    int          long_stall_done = 0;
    int          n_queued = 0;
    int          n_accepted = 0;
    int          fail_count = 0;

    endian_view_load_store_unit_top #(
        .STORE_BYTES(MEM_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),   // offset, write_value
        .i_s_axis_tuser (i_s_axis_tuser),   // action, access_kind, lsb_first
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),   // read_value
        .o_m_axis_tuser (o_m_axis_tuser)    // status
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // element size in bytes
    function automatic int unsigned elem_bytes(input logic [2:0] kind);
        case (kind)
            evl_pkg::KIND_INT8, evl_pkg::KIND_UINT8:     return 1;
            evl_pkg::KIND_INT16, evl_pkg::KIND_UINT16:   return 2;
            evl_pkg::KIND_INT32, evl_pkg::KIND_UINT32,
            evl_pkg::KIND_FLT32:                         return 4;
            default:                                     return 8;
        endcase
    endfunction

    // window start, clamped to the store end
    function automatic int unsigned window_base();
        return (win_base_reg > MEM_BYTES) ? MEM_BYTES : win_base_reg;
    endfunction

    // window length, cut so the window ends inside the store
    function automatic int unsigned window_len();
        int unsigned b;
        b = window_base();
        return (win_len_reg > MEM_BYTES - b) ? MEM_BYTES - b : win_len_reg;
    endfunction

    // expected outcome of one accepted request, store image updated on writes
    task automatic model_access(input t_access rq);
        logic        act;
        logic        le;
        logic [2:0]  kind;
        logic [15:0] ofs;
        logic [63:0] wv;
        logic [63:0] raw;
        int unsigned nb;
        int unsigned addr;
        int unsigned pos;
        t_outcome    res;
        act  = rq.user[0];
        kind = rq.user[3:1];
        le   = rq.user[4];
        ofs  = rq.data[15:0];
        wv   = rq.data[79:16];
        nb   = elem_bytes(kind);
        res.value  = '0;
        res.status = evl_pkg::STATUS_DONE;
        raw = '0;
        if (ofs + nb > window_len()) begin
            res.status = evl_pkg::STATUS_RANGE;
        end else begin
            addr = window_base() + ofs;
            for (int i = 0; i < nb; i++) begin
                pos = le ? i : nb - 1 - i;
                if (act == evl_pkg::ACT_WRITE) begin
                    mem_image[addr + pos] = wv[8*i +: 8];
                end else begin
                    raw[8*i +: 8] = mem_image[addr + pos];
                end
            end
            if (act == evl_pkg::ACT_READ) begin
                case (kind)
                    evl_pkg::KIND_INT8:  res.value = {{56{raw[7]}}, raw[7:0]};
                    evl_pkg::KIND_INT16: res.value = {{48{raw[15]}}, raw[15:0]};
                    evl_pkg::KIND_INT32: res.value = {{32{raw[31]}}, raw[31:0]};
                    default:             res.value = raw;
                endcase
            end
        end
        outcome_fifo.push_back(res);
    endtask

    // compare one returned result with the oldest expectation
    task automatic check_outcome(input logic [63:0] value, input logic status);
        t_outcome exp_res;
        if (outcome_fifo.size() == 0) begin
            fail_count++;
            $display("%0t: result expected none actual value %h status %b",
                     $time, value, status);
        end else begin
            exp_res = outcome_fifo.pop_front();
            if (value !== exp_res.value) begin
                fail_count++;
                $display("%0t: read_value expected %h actual %h", $time, exp_res.value, value);
            end
            if (status !== exp_res.status) begin
                fail_count++;
                $display("%0t: status expected %b actual %b", $time, exp_res.status, status);
            end
        end
    endtask

    // sample both streams at the rising edge
    always @(posedge i_clk) begin : bus_monitor
        t_access seen;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_outcome(o_m_axis_tdata, o_m_axis_tuser);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                seen.data = i_s_axis_tdata;
                seen.user = i_s_axis_tuser;
                model_access(seen);
                n_accepted++;
            end
        end
        req_accepted <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
    end

    // request driver, fed from the pending queue, with random gaps
    always @(negedge i_clk) begin : req_driver
        logic        nv;
        logic [79:0] nd;
        logic [7:0]  nu;
        t_access     rq;
        nv = i_s_axis_tvalid && !req_accepted;
        nd = i_s_axis_tdata;
        nu = i_s_axis_tuser;
        if (!nv) begin
            if (send_gap != 0) begin
                send_gap--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 11);
            end else if (request_fifo.size() != 0) begin
                rq = request_fifo.pop_front();
                nv = 1'b1;
                nd = rq.data;
                nu = rq.user;
            end
        end
        i_s_axis_tvalid <= nv;
        i_s_axis_tdata  <= nd;
        i_s_axis_tuser  <= nu;
    end

    // result sink with random back-pressure and the odd long hold-off
    always @(negedge i_clk) begin : result_sink
        logic nr;
        if (hold_cnt != 0) begin
            hold_cnt--;
            nr = 1'b0;
        end else if (long_stall_ask != long_stall_done) begin
            long_stall_done++;
            hold_cnt = LONG_HOLD - 1;
            nr = 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_cnt = $urandom_range(0, 11);
            nr = 1'b0;
        end else begin
            nr = 1'b1;
        end
        i_m_axis_tready <= nr;
    end

    // queue one request
    task automatic queue_access(input logic act, input logic [2:0] kind,
                                input logic [15:0] ofs, input logic le,
                                input logic [63:0] wv);
        t_access rq;
        rq.data = {wv, ofs};
        rq.user = {3'b000, le, kind, act};
        request_fifo.push_back(rq);
        n_queued++;
    endtask

    // register write, only issued while the unit is idle
    task automatic write_cfg(input logic [evl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [evl_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        if (idx == evl_pkg::CFG_VIEW_BASE) begin
            win_base_reg = val;
        end else begin
            win_len_reg = val;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every request is taken and every result is back
    task automatic drain();
        while (n_accepted != n_queued || outcome_fifo.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // random traffic, mostly store then load-back inside the window
    task automatic queue_random(input int count);
        int          n;
        int unsigned sel;
        int unsigned lim;
        logic [2:0]  kind;
        logic [2:0]  rkind;
        logic [15:0] ofs;
        logic        le;
        n = 0;
        lim = window_len();
        while (n < count) begin
            sel  = $urandom_range(0, 9);
            kind = 3'($urandom_range(0, 7));
            le   = 1'($urandom_range(0, 1));
            if (lim >= elem_bytes(kind)) begin
                ofs = 16'($urandom_range(0, lim - elem_bytes(kind)));
            end else begin
                ofs = 16'($urandom_range(0, 8));
            end
            if (sel < 6) begin
                queue_access(evl_pkg::ACT_WRITE, kind, ofs, le, {$urandom, $urandom});
                rkind = ($urandom_range(0, 1) == 0) ? kind : 3'($urandom_range(0, 7));
                if ($urandom_range(0, 3) == 0) le = ~le;
                queue_access(evl_pkg::ACT_READ, rkind, ofs, le, {$urandom, $urandom});
                n += 2;
            end else begin
                // near the window end, or anywhere in the offset range
                if (sel < 8) begin
                    ofs = (lim > 8) ? 16'($urandom_range(lim - 8, lim + 2))
                                    : 16'($urandom_range(0, 10));
                end else begin
                    ofs = 16'($urandom_range(0, 65535));
                end
                queue_access(1'($urandom_range(0, 1)), kind, ofs, le, {$urandom, $urandom});
                n++;
            end
        end
    endtask

    // one configuration setting followed by random traffic
    task automatic run_phase(input logic [12:0] base, input logic [12:0] len,
                             input bit idle, input bit long_hold);
        write_cfg(evl_pkg::CFG_VIEW_BASE, base);
        write_cfg(evl_pkg::CFG_VIEW_LENGTH, len);
        idle_on = idle;
        if (long_hold) long_stall_ask++;
        queue_random(PHASE_SIZE);
        drain();
    endtask

    // main sequence
    initial begin : stimulus
        foreach (mem_image[i]) mem_image[i] = 8'h00;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed accesses with the reset window
        queue_access(evl_pkg::ACT_WRITE, evl_pkg::KIND_INT32,  16'd0,     1'b0,
                     64'hA5A5A5A5_8899AABB);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_INT8,   16'd0,     1'b0, 64'h0);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_UINT8,  16'd0,     1'b1, 64'h0);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_INT16,  16'd0,     1'b0, 64'h0);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_UINT16, 16'd0,     1'b1, 64'h0);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_INT32,  16'd0,     1'b1, 64'h0);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_UINT32, 16'd0,     1'b0, 64'h0);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_FLT32,  16'd0,     1'b0, 64'h0);
        queue_access(evl_pkg::ACT_WRITE, evl_pkg::KIND_FLT64,  16'd4088,  1'b1,
                     64'h80000000_00000001);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_FLT64,  16'd4088,  1'b0, 64'h0);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_FLT64,  16'd4088,  1'b1, 64'h0);
        // element running past the window end
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_FLT64,  16'd4089,  1'b1, 64'h0);
        queue_access(evl_pkg::ACT_WRITE, evl_pkg::KIND_INT8,   16'd4095,  1'b0,
                     64'hFFFFFFFF_FFFFFFFF);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_INT8,   16'd4095,  1'b0, 64'h0);
        queue_access(evl_pkg::ACT_WRITE, evl_pkg::KIND_INT16,  16'd4095,  1'b1,
                     64'hFFFFFFFF_FFFFFFFF);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_UINT32, 16'd65535, 1'b1, 64'h0);
        queue_access(evl_pkg::ACT_WRITE, evl_pkg::KIND_UINT16, 16'd1,     1'b1,
                     64'h7FFFFFFF_FFFFFFFF);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_FLT64,  16'd0,     1'b0, 64'h0);
        // unaligned element across an 8-byte row
        queue_access(evl_pkg::ACT_WRITE, evl_pkg::KIND_UINT32, 16'd6,     1'b1, 64'h0);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_FLT64,  16'd3,     1'b1, 64'h0);
        queue_access(evl_pkg::ACT_WRITE, evl_pkg::KIND_INT16,  16'd15,    1'b0,
                     64'h00000000_00008001);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_INT16,  16'd15,    1'b0, 64'h0);
        queue_access(evl_pkg::ACT_READ,  evl_pkg::KIND_UINT16, 16'd15,    1'b1, 64'h0);
        drain();

        // random phases over several window settings
        run_phase(13'd0,    13'd4096, 1'b1, 1'b0);
        run_phase(13'd2048, 13'd2048, 1'b1, 1'b1);
        run_phase(13'd4096, 13'd4096, 1'b1, 1'b0);
        run_phase(13'd8191, 13'd8191, 1'b1, 1'b0);
        run_phase(13'd100,  13'd8191, 1'b1, 1'b0);
        run_phase(13'd17,   13'd0,    1'b1, 1'b0);
        run_phase(13'd4000, 13'd96,   1'b1, 1'b0);
        run_phase(13'd3,    13'd50,   1'b0, 1'b0);

        // let any late result show up
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && outcome_fifo.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run time limit
    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== endian_view_load_store_unit_top.f =====
+incdir+rtl
rtl/evl_pkg.sv
rtl/evl_ram.sv
rtl/evl_bytes.sv
rtl/endian_view_load_store_unit_top.sv
sim/testbench.sv
